// ===== rtl/core/wavpcm_pkg.sv =====
// shared types and constants for the wav stream parser
`default_nettype none
package wavpcm_pkg;
   typedef struct packed {
      logic [7:0] in_byte;
      logic       start_of_file;
   } req_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic signed [31:0] sample_value;
      logic [5:0]         channel_index;
      logic               is_float;
      logic [31:0]        sample_rate;
      logic [15:0]        channel_count;
      logic [7:0]         sample_bits;
   } rsp_type;

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_FMT_OK = 2'd1;
   localparam logic [1:0] KIND_FMT_BAD = 2'd2;
   localparam logic [1:0] KIND_NOT_WAV = 2'd3;

   localparam logic [31:0] TAG_RIFF = 32'h46464952;
   localparam logic [31:0] TAG_WAVE = 32'h45564157;
   localparam logic [31:0] TAG_FMT = 32'h20746d66;
   localparam logic [31:0] TAG_DATA = 32'h61746164;
   localparam logic [31:0] TAG_BEXT = 32'h74786562;
   localparam logic [31:0] TAG_SMPL = 32'h6c706d73;
   localparam logic [15:0] FMT_PCM = 16'h0001;
   localparam logic [15:0] FMT_FLOAT = 16'h0003;
   localparam logic [15:0] FMT_EXT = 16'hfffe;

   function automatic logic [7:0] guid_pcm(input logic [3:0] i);
      logic [127:0] g;
      g = 128'h719b3800aa000080_0010000000000001;
      return g[8*i +: 8];
   endfunction

   function automatic logic [7:0] guid_amb(input logic [3:0] i);
      logic [127:0] g;
      g = 128'h000000cac1c84486_11d3072100000001;
      return g[8*i +: 8];
   endfunction
endpackage
`default_nettype wire

// ===== rtl/core/wav_stream_parser_pcm_unpacker.sv =====
// wav stream parser top: input queue, chunk/sample back end, mask register
// an accepted byte passes the input queue, and any result it yields is registered in the back end;
// one byte per cycle in steady state while rsp_ready holds and no divide is running.
// a format report stalls the stream at the report byte while the shared serial divider
// derives frame bytes and then bits per sample. the two-entry input queue takes up to
// two bytes while the back end waits on the divider or on rsp_ready. synchronous
// active-high reset clears parser state, the queue and sets the channel mask to all ones.
`default_nettype none
module wav_stream_parser_pcm_unpacker #(
   parameter int MAX_CHANNELS = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire wavpcm_pkg::req_type req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output wavpcm_pkg::rsp_type      rsp_data,
   input  wire logic                csr_we,
   input  wire logic [63:0]         csr_wdata
);
   logic [63:0] mask_ff;
   logic        q_full, q_empty, q_pop;
   wavpcm_pkg::req_type q_data;

   always_ff @(posedge clock) begin
      if (reset) mask_ff <= '1;
      else if (csr_we) mask_ff <= csr_wdata;
   end

   assign req_ready = !q_full;

   wavpcm_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (req_valid && !q_full),
      .push_data(req_data),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_data),
      .empty    (q_empty)
   );

   wavpcm_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .chan_mask (mask_ff),
      .item      (q_data),
      .item_valid(!q_empty),
      .item_pop  (q_pop),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );
endmodule
`default_nettype wire

// ===== rtl/core/wavpcm_fifo.sv =====
// short queue of accepted input bytes between front and back
`default_nettype none
module wavpcm_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire wavpcm_pkg::req_type push_data,
   output logic                     full,
   input  wire logic                pop,
   output wavpcm_pkg::req_type      pop_data,
   output logic                     empty
);
   wavpcm_pkg::req_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign pop_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/wavpcm_div.sv =====
// shared radix-2 restoring divider, 35-bit dividend by 32-bit divisor
`default_nettype none
module wavpcm_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [34:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             busy,
   output logic [34:0]      quotient
);
   logic [5:0]  cnt_ff;
   logic [34:0] quo_ff;
   logic [32:0] rem_ff;
   logic [31:0] dvs_ff;
   logic [33:0] trial;

   assign busy = (cnt_ff != 6'd0);
   assign quotient = quo_ff;
   assign trial = {rem_ff, quo_ff[34]} - {2'b00, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 6'd0;
      end else if (start) begin
         cnt_ff <= 6'd35;
      end else if (busy) begin
         cnt_ff <= cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= 33'd0;
         dvs_ff <= divisor;
      end else if (busy) begin
         if (!trial[33]) begin
            rem_ff <= trial[32:0];
            quo_ff <= {quo_ff[33:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[31:0], quo_ff[34]};
            quo_ff <= {quo_ff[33:0], 1'b0};
         end
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/wavpcm_back.sv =====
// back end: chunk walk, format decode and sample unpacking
`default_nettype none
module wavpcm_back #(
   parameter int MAX_CHANNELS = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [63:0]         chan_mask,
   input  wire wavpcm_pkg::req_type item,
   input  wire logic                item_valid,
   output logic                     item_pop,
   output wavpcm_pkg::rsp_type      rsp_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready
);
   localparam logic [3:0] PH_RIFF = 4'd0;
   localparam logic [3:0] PH_RLEN = 4'd1;
   localparam logic [3:0] PH_WAVE = 4'd2;
   localparam logic [3:0] PH_CHDR = 4'd3;
   localparam logic [3:0] PH_FMT = 4'd4;
   localparam logic [3:0] PH_SKIP = 4'd5;
   localparam logic [3:0] PH_DATA = 4'd6;
   localparam logic [3:0] PH_PAD = 4'd7;
   localparam logic [3:0] PH_DONE = 4'd8;
   localparam logic [3:0] PH_DIV1 = 4'd9;
   localparam logic [3:0] PH_DIV2 = 4'd10;

   logic [3:0]  phase_ff, phase_in;
   logic [5:0]  bcnt_ff, bcnt_in;
   logic [31:0] riff_ff, riff_in;
   logic [32:0] crem_ff, crem_in;
   logic [63:0] shift_ff, shift_in;
   logic [31:0] fbytes_ff, fbytes_in;
   logic [31:0] bps_ff, bps_in;
   logic        fvalid_ff, fvalid_in;
   logic [31:0] asm_ff, asm_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] dcnt_ff, dcnt_in;
   logic [2:0]  sbyte_ff, sbyte_in;
   logic        pad_ff, pad_in;
   logic        whole_ff, whole_in;
   logic        extw_ff, extw_in;
   logic        gpcm_ff, gpcm_in;
   logic        gamb_ff, gamb_in;
   logic        flt_ff, flt_in;
   logic        tagok_ff, tagok_in;
   logic        end_ff, end_in;
   logic [15:0] ftag_ff, ftag_in;
   logic [15:0] fch_ff, fch_in;
   logic [31:0] frate_ff, frate_in;
   logic [31:0] fbps_ff, fbps_in;
   logic        rv_ff, rv_in;
   wavpcm_pkg::rsp_type rd_ff, rd_in;

   logic        div_start, div_busy;
   logic [34:0] div_dvd, div_q;
   logic [31:0] div_dvs;

   wavpcm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dvd),
      .divisor (div_dvs),
      .busy    (div_busy),
      .quotient(div_q)
   );

   assign rsp_data = rd_ff;
   assign rsp_valid = rv_ff;

   logic        can_work;
   logic [63:0] sh;
   logic [31:0] l32;
   logic [5:0]  off;
   logic [32:0] crem_dec;
   logic [31:0] sbits;
   logic [2:0]  sb;
   logic [33:0] area;
   logic [31:0] v;
   logic [31:0] asm_new;
   logic [2:0]  sbyte_new;
   logic [31:0] dcnt_new;
   logic [7:0]  b;
   logic [3:0]  gidx;
   logic        emit;
   logic [1:0]  ekind;
   logic [31:0] eval;
   logic [5:0]  ech;
   logic        after_end;
   logic        bits_ok;

   always_comb begin
      phase_in = phase_ff; bcnt_in = bcnt_ff; riff_in = riff_ff; crem_in = crem_ff;
      shift_in = shift_ff; fbytes_in = fbytes_ff; bps_in = bps_ff; fvalid_in = fvalid_ff;
      asm_in = asm_ff; chan_in = chan_ff; dcnt_in = dcnt_ff; sbyte_in = sbyte_ff;
      pad_in = pad_ff; whole_in = whole_ff; extw_in = extw_ff; gpcm_in = gpcm_ff;
      gamb_in = gamb_ff; flt_in = flt_ff; tagok_in = tagok_ff; end_in = end_ff;
      ftag_in = ftag_ff; fch_in = fch_ff; frate_in = frate_ff; fbps_in = fbps_ff;
      rv_in = rv_ff; rd_in = rd_ff;
      item_pop = 1'b0; div_start = 1'b0; div_dvd = 35'd0; div_dvs = 32'd0;
      emit = 1'b0; ekind = wavpcm_pkg::KIND_SAMPLE; eval = 32'd0; ech = 6'd0;
      after_end = 1'b0;
      b = item.in_byte;
      sh = {b, shift_ff[63:8]};
      l32 = sh[63:32];
      off = bcnt_ff;
      crem_dec = crem_ff - 33'd1;
      sbits = bps_ff;
      sb = sbits[5:3];
      area = {2'b00, fch_ff} * {29'd0, sb};
      v = 32'd0; asm_new = asm_ff; sbyte_new = sbyte_ff; dcnt_new = dcnt_ff;
      gidx = 4'(off - 6'd24);
      bits_ok = (sbits == 32'd8) || (sbits == 32'd16) || (sbits == 32'd24)
         || (sbits == 32'd32);
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      can_work = !rv_ff || rsp_ready;

      if (phase_ff == PH_DIV1) begin
         // frame bytes = bytes/sec over rate
         if (!div_busy) begin
            fbytes_in = (frate_ff == 32'd0) ? 32'd0 : div_q[31:0];
            div_start = 1'b1;
            div_dvd = {(frate_ff == 32'd0) ? 32'd0 : div_q[31:0], 3'b000};
            div_dvs = (fch_ff == 16'd0) ? 32'd1 : {16'd0, fch_ff};
            phase_in = PH_DIV2;
         end
      end else if (phase_ff == PH_DIV2) begin
         if (!div_busy && can_work) begin
            bps_in = (fch_ff == 16'd0) ? 32'd0 :
               ((div_q[34:32] != 3'd0) ? 32'hffffffff : div_q[31:0]);
            flt_in = (ftag_ff == wavpcm_pkg::FMT_FLOAT);
            fvalid_in = tagok_ff && (fbytes_ff != 32'd0) && (fch_ff != 16'd0);
            rv_in = 1'b1;
            rd_in.result_kind = fvalid_in ? wavpcm_pkg::KIND_FMT_OK
               : wavpcm_pkg::KIND_FMT_BAD;
            rd_in.sample_value = 32'sd0;
            rd_in.channel_index = 6'd0;
            rd_in.is_float = flt_in;
            rd_in.sample_rate = frate_ff;
            rd_in.channel_count = fch_ff;
            rd_in.sample_bits = (bps_in > 32'd255) ? 8'd255 : bps_in[7:0];
            if (end_ff) begin
               phase_in = pad_ff ? PH_PAD : ((riff_ff == 32'd0) ? PH_DONE : PH_CHDR);
               bcnt_in = 6'd0;
            end else begin
               phase_in = PH_FMT;
            end
         end
      end else if (item_valid && can_work) begin
         item_pop = 1'b1;
         if (item.start_of_file) begin
            phase_in = PH_RIFF; bcnt_in = 6'd0; riff_in = 32'd0; crem_in = 33'd0;
            sh = {b, 56'd0}; l32 = {b, 24'd0};
            fbytes_in = 32'd0; bps_in = 32'd0; fvalid_in = 1'b0; asm_in = 32'd0;
            chan_in = 16'd0; dcnt_in = 32'd0; sbyte_in = 3'd0; pad_in = 1'b0;
            whole_in = 1'b0; extw_in = 1'b0; gpcm_in = 1'b0; gamb_in = 1'b0;
            flt_in = 1'b0; ftag_in = 16'd0; fch_in = 16'd0; frate_in = 32'd0;
            fbps_in = 32'd0;
            off = 6'd0;
         end
         if (item.start_of_file || phase_ff != PH_DONE) begin
            shift_in = sh;
            if (phase_in >= PH_WAVE && riff_in != 32'd0) riff_in = riff_in - 32'd1;
            unique case (phase_in)
               PH_RIFF, PH_RLEN, PH_WAVE: begin
                  bcnt_in = off + 6'd1;
                  if (off == 6'd3) begin
                     bcnt_in = 6'd0;
                     if (phase_in == PH_RLEN) begin
                        riff_in = l32;
                        phase_in = PH_WAVE;
                     end else if (l32 != ((phase_in == PH_RIFF) ? wavpcm_pkg::TAG_RIFF
                                          : wavpcm_pkg::TAG_WAVE)) begin
                        emit = 1'b1; ekind = wavpcm_pkg::KIND_NOT_WAV;
                        phase_in = PH_DONE;
                     end else if (phase_in == PH_RIFF) begin
                        phase_in = PH_RLEN;
                     end else begin
                        phase_in = (riff_in == 32'd0) ? PH_DONE : PH_CHDR;
                     end
                  end
               end
               PH_CHDR: begin
                  bcnt_in = off + 6'd1;
                  if (off == 6'd7) begin
                     bcnt_in = 6'd0;
                     crem_in = {1'b0, l32};
                     pad_in = l32[0];
                     after_end = (l32 == 32'd0);
                     if (sh[31:0] == wavpcm_pkg::TAG_FMT) begin
                        if (l32 < 32'd16) begin
                           ftag_in = 16'd0; fch_in = 16'd0; frate_in = 32'd0;
                           fbps_in = 32'd0; fbytes_in = 32'd0; bps_in = 32'd0;
                           fvalid_in = 1'b0; flt_in = 1'b0;
                           emit = 1'b1; ekind = wavpcm_pkg::KIND_FMT_BAD;
                           phase_in = PH_SKIP;
                        end else begin
                           extw_in = 1'b0;
                           phase_in = PH_FMT;
                        end
                     end else if (sh[31:0] == wavpcm_pkg::TAG_DATA) begin
                        sbyte_in = 3'd0; chan_in = 16'd0; asm_in = 32'd0;
                        whole_in = 1'b0; dcnt_in = 32'd0;
                        phase_in = PH_DATA;
                     end else if (sh[31:0] == wavpcm_pkg::TAG_BEXT
                                  || sh[31:0] == wavpcm_pkg::TAG_SMPL) begin
                        phase_in = PH_SKIP;
                     end else if (l32 == 32'd0) begin
                        phase_in = PH_DONE;
                        after_end = 1'b0;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end
               end
               PH_FMT: begin
                  crem_in = crem_dec;
                  if (off < 6'd40) bcnt_in = off + 6'd1;
                  after_end = (crem_dec == 33'd0);
                  end_in = after_end;
                  if (off == 6'd1) ftag_in = sh[63:48];
                  else if (off == 6'd3) fch_in = sh[63:48];
                  else if (off == 6'd7) frate_in = l32;
                  else if (off == 6'd11) begin
                     fbps_in = l32;
                     if (ftag_ff == wavpcm_pkg::FMT_EXT && crem_dec >= 33'd28) begin
                        extw_in = 1'b1; gpcm_in = 1'b1; gamb_in = 1'b1;
                     end else begin
                        tagok_in = (ftag_ff == wavpcm_pkg::FMT_PCM)
                           || (ftag_ff == wavpcm_pkg::FMT_FLOAT);
                        div_start = 1'b1; div_dvd = {3'b000, l32}; div_dvs = frate_ff;
                        phase_in = PH_DIV1; after_end = 1'b0;
                     end
                  end else if (extw_ff && off >= 6'd24 && off <= 6'd39) begin
                     if (b != wavpcm_pkg::guid_pcm(gidx)) gpcm_in = 1'b0;
                     if (b != wavpcm_pkg::guid_amb(gidx)) gamb_in = 1'b0;
                     if (off == 6'd39) begin
                        extw_in = 1'b0;
                        tagok_in = gpcm_in || gamb_in;
                        div_start = 1'b1; div_dvd = {3'b000, fbps_ff}; div_dvs = frate_ff;
                        phase_in = PH_DIV1; after_end = 1'b0;
                     end
                  end
               end
               PH_SKIP: begin
                  crem_in = crem_dec;
                  after_end = (crem_dec == 33'd0);
               end
               PH_DATA: begin
                  crem_in = crem_dec;
                  after_end = (crem_dec == 33'd0);
                  if (fvalid_ff && bits_ok) begin
                     whole_in = whole_ff;
                     if (dcnt_ff == 32'd0) begin
                        whole_in = (crem_ff >= {1'b0, fbytes_ff});
                        chan_in = 16'd0; sbyte_new = 3'd0; asm_new = 32'd0;
                     end
                     if (whole_in && {2'b00, dcnt_ff} < area) begin
                        asm_new = asm_new | ({24'd0, b} << {sbyte_new[1:0], 3'b000});
                        sbyte_new = sbyte_new + 3'd1;
                        if (sbyte_new == sb) begin
                           unique case (sb)
                              3'd1: v = {asm_new[7:0] ^ 8'h80, 24'd0};
                              3'd2: v = {asm_new[15:0], 16'd0};
                              3'd3: v = {asm_new[23:0], 8'd0};
                              default: v = asm_new;
                           endcase
                           if (chan_in < 16'(MAX_CHANNELS) && chan_mask[chan_in[5:0]]) begin
                              emit = 1'b1; ekind = wavpcm_pkg::KIND_SAMPLE;
                              eval = v; ech = chan_in[5:0];
                           end
                           chan_in = chan_in + 16'd1;
                           sbyte_new = 3'd0; asm_new = 32'd0;
                        end
                     end
                     asm_in = asm_new; sbyte_in = sbyte_new;
                     dcnt_new = dcnt_ff + 32'd1;
                     dcnt_in = (dcnt_new >= fbytes_ff) ? 32'd0 : dcnt_new;
                  end
               end
               PH_PAD: begin
                  bcnt_in = 6'd0;
                  phase_in = (riff_in == 32'd0) ? PH_DONE : PH_CHDR;
               end
               default: begin
               end
            endcase
            if (after_end) begin
               bcnt_in = 6'd0;
               phase_in = pad_in ? PH_PAD : ((riff_in == 32'd0) ? PH_DONE : PH_CHDR);
            end
            if (emit) begin
               rv_in = 1'b1;
               rd_in.result_kind = ekind;
               rd_in.sample_value = eval;
               rd_in.channel_index = ech;
               rd_in.is_float = (ekind == wavpcm_pkg::KIND_NOT_WAV) ? 1'b0 : flt_in;
               rd_in.sample_rate = frate_in;
               rd_in.channel_count = fch_in;
               rd_in.sample_bits = (bps_in > 32'd255) ? 8'd255 : bps_in[7:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RIFF; bcnt_ff <= 6'd0; riff_ff <= 32'd0; crem_ff <= 33'd0;
         shift_ff <= 64'd0; fbytes_ff <= 32'd0; bps_ff <= 32'd0; fvalid_ff <= 1'b0;
         asm_ff <= 32'd0; chan_ff <= 16'd0; dcnt_ff <= 32'd0; sbyte_ff <= 3'd0;
         pad_ff <= 1'b0; whole_ff <= 1'b0; extw_ff <= 1'b0; gpcm_ff <= 1'b0;
         gamb_ff <= 1'b0; flt_ff <= 1'b0; tagok_ff <= 1'b0; end_ff <= 1'b0;
         ftag_ff <= 16'd0; fch_ff <= 16'd0; frate_ff <= 32'd0; fbps_ff <= 32'd0;
         rv_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; bcnt_ff <= bcnt_in; riff_ff <= riff_in; crem_ff <= crem_in;
         shift_ff <= shift_in; fbytes_ff <= fbytes_in; bps_ff <= bps_in;
         fvalid_ff <= fvalid_in; asm_ff <= asm_in; chan_ff <= chan_in; dcnt_ff <= dcnt_in;
         sbyte_ff <= sbyte_in; pad_ff <= pad_in; whole_ff <= whole_in; extw_ff <= extw_in;
         gpcm_ff <= gpcm_in; gamb_ff <= gamb_in; flt_ff <= flt_in; tagok_ff <= tagok_in;
         end_ff <= end_in; ftag_ff <= ftag_in; fch_ff <= fch_in; frate_ff <= frate_in;
         fbps_ff <= fbps_in; rv_ff <= rv_in;
      end
      rd_ff <= rd_in;
   end
endmodule
`default_nettype wire
